/* rtl/bdeg_pkg.sv */
// ----------------------------------------------------------------------------
// bdeg_pkg: shared types and constants for the button debounce event unit
// Holds the button count, event and register codes, and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdeg_pkg;

    // Number of buttons on the port; only the first eight are ever handled
    localparam int BUTTON_COUNT = 8;
    localparam int BTN_N        = (BUTTON_COUNT < 8) ? BUTTON_COUNT : 8;
    localparam logic [2:0] LAST_IDX = 3'(BTN_N - 1);

    // Configuration register indexes
    localparam logic [2:0] REG_ACTIVE_LOW      = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_THRESH = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_TIME = 3'd2;
    localparam logic [2:0] REG_REPEAT_DELAY    = 3'd3;
    localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd4;

    // Event kinds
    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2,
        EV_REPEAT  = 2'd3
    } ev_kind_t;

    // Which evaluation the datapath does for the current button
    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_LONG   = 2'd1,
        PH_REPEAT = 2'd2,
        PH_NONE   = 2'd3
    } phase_t;

    // One event record
    typedef struct packed {
        ev_kind_t    kind;
        logic [2:0]  idx;
        logic [7:0]  mask;
        logic [31:0] stamp;
        logic [31:0] dur;
    } ev_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       step;
        logic       flush;
        phase_t     phase;
        logic [2:0] idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic evt;
        logic pend_valid;
        logic slot_free;
    } dp_stat_t;

endpackage

/* rtl/bdeg_ctrl.sv */
// ----------------------------------------------------------------------------
// bdeg_ctrl: sequencer for the button debounce event unit
// Walks the buttons once for debounce, then once more for long press and
// repeat, and finally flushes the held-back word marked as the last one.
// ----------------------------------------------------------------------------
module bdeg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bdeg_pkg::dp_stat_t  stat,
    output bdeg_pkg::dp_cmd_t   cmd
);
    import bdeg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_LONG   = 5'b00100,
        ST_REPEAT = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       proceed;

    // A step may commit unless it must push a pending word into a busy slot
    assign proceed  = !stat.evt || !stat.pend_valid || stat.slot_free;
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.flush  = 1'b0;
        cmd.phase  = PH_NONE;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = 3'd0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.phase = PH_SCAN;
                cmd.step  = proceed;
                if (proceed)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = 3'd0;
                        state_next = ST_LONG;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_LONG:
            begin
                cmd.phase = PH_LONG;
                cmd.step  = proceed;
                if (proceed)
                begin
                    state_next = ST_REPEAT;
                end
            end
            ST_REPEAT:
            begin
                cmd.phase = PH_REPEAT;
                cmd.step  = proceed;
                if (proceed)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_LONG;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = stat.pend_valid && stat.slot_free;
                if (!stat.pend_valid || stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/bdeg_datapath.sv */
// ----------------------------------------------------------------------------
// bdeg_datapath: per-button state, event evaluation and output staging
// Holds the configuration, the integrators and timing state of each button,
// one pending event word and the output register.
// ----------------------------------------------------------------------------
module bdeg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bdeg_pkg::dp_cmd_t   cmd,
    output bdeg_pkg::dp_stat_t  stat,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [7:0]          btn_sample,
    input  logic [31:0]         sample_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          event_kind,
    output logic [2:0]          button_index,
    output logic [7:0]          held_mask,
    output logic [31:0]         event_time,
    output logic [31:0]         hold_duration,
    output logic                last_event
);
    import bdeg_pkg::*;

    // Configuration
    logic        active_low_reg;
    logic [7:0]  thresh_reg;
    logic [15:0] long_time_reg;
    logic [15:0] rpt_delay_reg;
    logic [15:0] rpt_interval_reg;

    // Sample and per-button state
    logic [7:0]  pressed_reg;
    logic [31:0] time_reg;
    logic [7:0]  integ_reg [8];
    logic [7:0]  held_reg;
    logic [7:0]  long_rep_reg;
    logic [31:0] press_time_reg [8];
    logic [31:0] next_rpt_reg [8];

    // Output staging
    ev_t         pend_reg;
    logic        pend_valid_reg;
    ev_t         out_reg;
    logic        out_last_reg;
    logic        out_valid_reg;

    // Step evaluation
    logic [2:0]  i;
    logic [7:0]  onehot;
    logic [7:0]  integ_cur;
    logic [8:0]  integ_up;
    logic [7:0]  integ_next;
    logic        is_press;
    logic        is_release;
    logic [31:0] dur;
    logic [31:0] rpt_diff;
    logic        is_long;
    logic        is_rpt;
    logic        evt;
    ev_t         new_ev;
    logic        load_out;

    assign i         = cmd.idx;
    assign onehot    = 8'd1 << i;
    assign integ_cur = integ_reg[i];
    assign integ_up  = {1'b0, integ_cur} + 9'd1;
    assign dur       = time_reg - press_time_reg[i];
    assign rpt_diff  = time_reg - next_rpt_reg[i];

    // Saturating integrator update
    always_comb
    begin
        if (pressed_reg[i])
        begin
            integ_next = (integ_up < {1'b0, thresh_reg}) ? integ_up[7:0] : thresh_reg;
        end
        else if (integ_cur != 8'd0)
        begin
            integ_next = integ_cur - 8'd1;
        end
        else
        begin
            integ_next = integ_cur;
        end
    end

    assign is_press   = !held_reg[i] && (integ_next >= thresh_reg);
    assign is_release = held_reg[i] && (integ_next == 8'd0);
    assign is_long    = held_reg[i] && !long_rep_reg[i] && (dur >= {16'd0, long_time_reg});
    assign is_rpt     = held_reg[i] && (rpt_interval_reg != 16'd0) && !rpt_diff[31];

    // Select the event this step would produce
    always_comb
    begin
        evt          = 1'b0;
        new_ev.kind  = EV_PRESS;
        new_ev.idx   = i;
        new_ev.mask  = held_reg;
        new_ev.stamp = time_reg;
        new_ev.dur   = dur;
        case (cmd.phase)
            PH_SCAN:
            begin
                if (is_press)
                begin
                    evt         = 1'b1;
                    new_ev.kind = EV_PRESS;
                    new_ev.mask = held_reg | onehot;
                    new_ev.dur  = 32'd0;
                end
                else if (is_release)
                begin
                    evt         = 1'b1;
                    new_ev.kind = EV_RELEASE;
                    new_ev.mask = held_reg & ~onehot;
                end
            end
            PH_LONG:
            begin
                evt         = is_long;
                new_ev.kind = EV_LONG;
            end
            PH_REPEAT:
            begin
                evt         = is_rpt;
                new_ev.kind = EV_REPEAT;
            end
            default:
            begin
                evt = 1'b0;
            end
        endcase
    end

    assign stat.evt        = evt;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.slot_free  = !out_valid_reg || !out_stall;

    // Push the pending word out when a newer one arrives or at the flush
    assign load_out = (cmd.step && evt && pend_valid_reg) || cmd.flush;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg   <= 1'b1;
            thresh_reg       <= 8'd3;
            long_time_reg    <= 16'd1000;
            rpt_delay_reg    <= 16'd500;
            rpt_interval_reg <= 16'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACTIVE_LOW:      active_low_reg   <= cfg_data[0];
                REG_DEBOUNCE_THRESH: thresh_reg       <= cfg_data[7:0];
                REG_LONG_PRESS_TIME: long_time_reg    <= cfg_data;
                REG_REPEAT_DELAY:    rpt_delay_reg    <= cfg_data;
                REG_REPEAT_INTERVAL: rpt_interval_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Button control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                integ_reg[k] <= 8'd0;
            end
            held_reg     <= 8'd0;
            long_rep_reg <= 8'd0;
        end
        else if (cmd.step)
        begin
            case (cmd.phase)
                PH_SCAN:
                begin
                    integ_reg[i] <= integ_next;
                    if (is_press)
                    begin
                        held_reg[i]     <= 1'b1;
                        long_rep_reg[i] <= 1'b0;
                    end
                    else if (is_release)
                    begin
                        held_reg[i]     <= 1'b0;
                        long_rep_reg[i] <= 1'b0;
                    end
                end
                PH_LONG:
                begin
                    if (is_long)
                    begin
                        long_rep_reg[i] <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sample capture and timing state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pressed_reg <= active_low_reg ? ~btn_sample : btn_sample;
            time_reg    <= sample_time;
        end
        if (cmd.step && (cmd.phase == PH_SCAN) && is_press)
        begin
            press_time_reg[i] <= time_reg;
            next_rpt_reg[i]   <= time_reg + {16'd0, rpt_delay_reg};
        end
        if (cmd.step && (cmd.phase == PH_REPEAT) && is_rpt)
        begin
            next_rpt_reg[i] <= time_reg + {16'd0, rpt_interval_reg};
        end
    end

    // Pending and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step && evt)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pending and output words
    always_ff @(posedge clk)
    begin
        if (cmd.step && evt)
        begin
            pend_reg <= new_ev;
        end
        if (load_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_reg.kind;
    assign button_index  = out_reg.idx;
    assign held_mask     = out_reg.mask;
    assign event_time    = out_reg.stamp;
    assign hold_duration = out_reg.dur;
    assign last_event    = out_last_reg;

endmodule

/* rtl/button_debounce_event_gen_unit.sv */
// ----------------------------------------------------------------------------
// button_debounce_event_gen_unit: debounced button events with long press
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Takes one 8-button port sample with its millisecond timestamp when in_stall
// is low, and emits its press, release, long-press and repeat events as a
// stream of words on the output channel, the final word of a sample marked by
// last_event. A sample occupies the unit through one capture step, the debounce
// scan of the eight buttons (one button a cycle unless a stalled output holds
// the step), the long-press and repeat checks (two steps a button) and one
// step to flush the last word; output stalls add to that. The sample rate
// is bound by this sequencer walking the buttons through the one shared
// evaluation unit. Configuration writes are taken at any time (cfg_ready is
// always high) but belong in idle periods.
// ----------------------------------------------------------------------------
module button_debounce_event_gen_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  btn_sample,
    input  logic [31:0] sample_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [2:0]  button_index,
    output logic [7:0]  held_mask,
    output logic [31:0] event_time,
    output logic [31:0] hold_duration,
    output logic        last_event
);
    import bdeg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    bdeg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    bdeg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .btn_sample    (btn_sample),
        .sample_time   (sample_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .button_index  (button_index),
        .held_mask     (held_mask),
        .event_time    (event_time),
        .hold_duration (hold_duration),
        .last_event    (last_event)
    );

endmodule
